// ----- rtl/tsrc_pkg.sv -----
// ---------------------------------------------------------------------------
// tsrc_pkg: shared definitions for the tour store
// Operation codes, controller states and default sizes.
// ---------------------------------------------------------------------------
package tsrc_pkg;

  localparam int GENOME_MAX_DEF = 1024;
  localparam int ENTRY_BITS_DEF = 16;
  localparam int LEN_BITS       = 11;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_REVERSE = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_REV_RD_LO,
    ST_REV_RD_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_CLR,
    ST_CHK_RD,
    ST_CHK_VAL,
    ST_CHK_INC,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/tsrc_ram.sv -----
// ---------------------------------------------------------------------------
// tsrc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tsrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tour_store_reverse_and_check_top.sv -----
// ---------------------------------------------------------------------------
// tour_store_reverse_and_check_top: tour store with reversal and check
// Holds one city permutation in a RAM; writes, reads, reverses a range of
// entries and checks that the tour is a valid permutation.
// ---------------------------------------------------------------------------
// One request is handled at a time; the next is taken once the result is in
// the output register. With L the effective tour length (tour_length capped
// at GENOME_MAX), a write or a read is a single RAM access, a reversal swaps
// entry pairs from both ends inward (it is ignored unless both positions lie
// below L and differ), and a check clears the seen-count RAM in one sweep,
// reads each of the L entries and updates its count, then reads the counts
// back in a second sweep. Each RAM has a single read port; a stalled output
// holds the controller in its finish state. An entry never written reads as garbage.
// tour_length may only be changed while no request is in flight.
module tour_store_reverse_and_check_top
  import tsrc_pkg::*;
#(
  parameter int GENOME_MAX = GENOME_MAX_DEF,
  parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [9:0]          position_a,
  input  logic [9:0]          position_b,
  input  logic signed [15:0]  write_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  read_value,
  output logic                is_permutation,
  output logic                entry_out_of_range
);

  localparam int AW = $clog2(GENOME_MAX);
  localparam int LW = $clog2(GENOME_MAX + 1);
  localparam int EW = ENTRY_BITS;

  state_t state, state_next;

  logic [LEN_BITS-1:0] tour_length;
  logic [LW-1:0]       eff_len;

  op_t              op_q;
  logic [9:0]       pa_q, pb_q;
  logic signed [15:0] wv_q;

  logic [AW-1:0] lo, lo_next, hi, hi_next, val, val_next;
  logic [LW-1:0] idx, idx_next;
  logic [EW-1:0] tmp, tmp_next;
  logic          bad, bad_next, ok, ok_next, pend, pend_next, perm, perm_next;
  logic signed [15:0] rv, rv_next;

  logic          t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [EW-1:0] t_wdata, t_rdata;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [1:0]    s_wdata, s_rdata;

  logic pa_in_store, rev_ok, slot_free;

  tsrc_ram #(.WIDTH(EW), .DEPTH(GENOME_MAX)) u_tour_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tsrc_ram #(.WIDTH(2), .DEPTH(GENOME_MAX)) u_seen_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tour_length <= LEN_RESET;
    end else if (cfg_we) begin
      tour_length <= cfg_wdata;
    end
  end

  assign eff_len = (32'(tour_length) > 32'(GENOME_MAX)) ? LW'(GENOME_MAX)
                                                        : LW'(tour_length);

  assign in_ready    = (state == ST_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign pa_in_store = 32'(pa_q) < 32'(GENOME_MAX);
  assign rev_ok      = (32'(pa_q) < 32'(eff_len)) && (32'(pb_q) < 32'(eff_len)) &&
                       (pa_q != pb_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= op_t'(op);
      pa_q <= position_a;
      pb_q <= position_b;
      wv_q <= write_value;
    end
    lo   <= lo_next;
    hi   <= hi_next;
    val  <= val_next;
    idx  <= idx_next;
    tmp  <= tmp_next;
    bad  <= bad_next;
    ok   <= ok_next;
    pend <= pend_next;
    perm <= perm_next;
    rv   <= rv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && slot_free) begin
      read_value         <= rv;
      is_permutation     <= perm;
      entry_out_of_range <= bad;
    end
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    val_next   = val;
    idx_next   = idx;
    tmp_next   = tmp;
    bad_next   = bad;
    ok_next    = ok;
    pend_next  = pend;
    perm_next  = perm;
    rv_next    = rv;
    t_we       = 1'b0;
    t_waddr    = lo;
    t_wdata    = t_rdata;
    t_raddr    = lo;
    s_we       = 1'b0;
    s_waddr    = val;
    s_wdata    = 2'd0;
    s_raddr    = val;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rv_next   = '0;
        bad_next  = 1'b0;
        perm_next = 1'b0;
        unique case (op_q)
          OP_WRITE: begin
            t_we       = pa_in_store;
            t_waddr    = AW'(pa_q);
            t_wdata    = EW'(wv_q);
            state_next = ST_FINISH;
          end
          OP_READ: begin
            t_raddr    = AW'(pa_q);
            state_next = ST_READ_WAIT;
          end
          OP_REVERSE: begin
            lo_next    = (pa_q < pb_q) ? AW'(pa_q) : AW'(pb_q);
            hi_next    = (pa_q < pb_q) ? AW'(pb_q) : AW'(pa_q);
            state_next = rev_ok ? ST_REV_RD_LO : ST_FINISH;
          end
          OP_CHECK: begin
            idx_next   = '0;
            state_next = ST_CLR;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_READ_WAIT: begin
        rv_next    = pa_in_store ? 16'($signed(t_rdata)) : 16'sd0;
        state_next = ST_FINISH;
      end
      ST_REV_RD_LO: begin
        t_raddr    = lo;
        state_next = (lo < hi) ? ST_REV_RD_HI : ST_FINISH;
      end
      ST_REV_RD_HI: begin
        t_raddr    = hi;
        tmp_next   = t_rdata;
        state_next = ST_REV_WR_LO;
      end
      ST_REV_WR_LO: begin
        t_we       = 1'b1;
        t_waddr    = lo;
        t_wdata    = t_rdata;
        state_next = ST_REV_WR_HI;
      end
      ST_REV_WR_HI: begin
        t_we       = 1'b1;
        t_waddr    = hi;
        t_wdata    = tmp;
        lo_next    = lo + AW'(1);
        hi_next    = hi - AW'(1);
        state_next = ST_REV_RD_LO;
      end
      ST_CLR: begin
        if (idx < eff_len) begin
          s_we     = 1'b1;
          s_waddr  = idx[AW-1:0];
          s_wdata  = 2'd0;
          idx_next = idx + LW'(1);
        end else begin
          idx_next   = '0;
          state_next = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        t_raddr = idx[AW-1:0];
        if (idx < eff_len) begin
          state_next = ST_CHK_VAL;
        end else begin
          idx_next   = '0;
          ok_next    = 1'b1;
          pend_next  = 1'b0;
          state_next = ST_SCAN;
        end
      end
      ST_CHK_VAL: begin
        if (t_rdata[EW-1] || (32'(t_rdata) >= 32'(eff_len))) begin
          bad_next   = 1'b1;
          idx_next   = idx + LW'(1);
          state_next = ST_CHK_RD;
        end else begin
          s_raddr    = AW'(t_rdata);
          val_next   = AW'(t_rdata);
          state_next = ST_CHK_INC;
        end
      end
      ST_CHK_INC: begin
        s_we       = s_rdata < 2'd2;
        s_waddr    = val;
        s_wdata    = s_rdata + 2'd1;
        idx_next   = idx + LW'(1);
        state_next = ST_CHK_RD;
      end
      ST_SCAN: begin
        s_raddr = idx[AW-1:0];
        if (pend && s_rdata != 2'd1) begin
          ok_next = 1'b0;
        end
        if (idx < eff_len) begin
          idx_next  = idx + LW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            perm_next  = ok && !bad;
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside finish");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_permutation && entry_out_of_range))
    else $error("permutation reported with bad entry");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REV_WR_LO || state == ST_REV_WR_HI) |-> lo < hi)
    else $error("swap with crossed ends");

  a_seen_write_src: assert property (@(posedge clk) disable iff (rst)
    s_we |-> (state == ST_CLR || state == ST_CHK_INC))
    else $error("seen store written outside a check");

  a_no_tour_write_in_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR || state == ST_CHK_RD || state == ST_CHK_VAL ||
     state == ST_CHK_INC || state == ST_SCAN) |-> !t_we)
    else $error("tour written during a check");

endmodule

// ----- tb/tb_tour_store_reverse_and_check_top.sv -----
// ---------------------------------------------------------------------------
// tb_tour_store_reverse_and_check_top: self-checking bench for the tour store
// Drives write, read, reverse and check requests over valid/ready, keeps its
// own copy of the tour to predict every result, and compares each result in
// order. Covers directed corner cases, a long tour, a long output stall and
// random tours of many lengths, with random idle bursts.
// ---------------------------------------------------------------------------
module tb_tour_store_reverse_and_check_top;
  import tsrc_pkg::*;

  localparam int GENOME_MAX     = GENOME_MAX_DEF;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_TOUR      = 160;
  localparam int RANDOM_REQUESTS = 360;
  localparam int QUIET_TAIL     = 60;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               is_permutation;
    logic               entry_out_of_range;
  } tour_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          op = OP_READ;
  logic [9:0]          position_a = '0;
  logic [9:0]          position_b = '0;
  logic signed [15:0]  write_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  read_value;
  logic                is_permutation;
  logic                entry_out_of_range;

  logic signed [15:0]  tour_copy [GENOME_MAX];
  bit [1:0]            city_count [GENOME_MAX];
  bit [LEN_BITS-1:0]   tour_length_copy = LEN_RESET;
  tour_result_t        expected_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  requests_sent = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  int  broken_tours = 0;
  int  length_settings = 0;
  int  send_gap_pct = 0;
  int  ready_gap_pct = 0;
  int  stall_left = 0;
  int  hold_off_asked = 0;
  int  hold_off_taken = 0;

  tour_store_reverse_and_check_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .position_a         (position_a),
    .position_b         (position_b),
    .write_value        (write_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .read_value         (read_value),
    .is_permutation     (is_permutation),
    .entry_out_of_range (entry_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, expected_results.size());
      $display("tour_store_reverse_and_check_top regression: fail");
      $finish;
    end
  end

  // tour model: applies one request to the local tour copy
  function automatic tour_result_t apply_tour_request(op_t kind, bit [9:0] pos_a,
                                                      bit [9:0] pos_b,
                                                      logic signed [15:0] value);
    tour_result_t       r;
    int                 span;
    int                 lo;
    int                 hi;
    logic signed [15:0] t;
    bit                 all_once;
    r = '0;
    span = (tour_length_copy > GENOME_MAX) ? GENOME_MAX : tour_length_copy;
    case (kind)
      OP_WRITE: begin
        tour_copy[pos_a] = value;
      end
      OP_READ: begin
        r.read_value = tour_copy[pos_a];
      end
      OP_REVERSE: begin
        if (pos_a < span && pos_b < span && pos_a != pos_b) begin
          lo = (pos_a < pos_b) ? pos_a : pos_b;
          hi = (pos_a < pos_b) ? pos_b : pos_a;
          while (lo < hi) begin
            t = tour_copy[lo];
            tour_copy[lo] = tour_copy[hi];
            tour_copy[hi] = t;
            lo++;
            hi--;
          end
        end
      end
      default: begin
        all_once = 1'b1;
        for (int i = 0; i < GENOME_MAX; i++) city_count[i] = 2'd0;
        for (int i = 0; i < span; i++) begin
          if (tour_copy[i] < 0 || tour_copy[i] >= span) begin
            r.entry_out_of_range = 1'b1;
          end else if (city_count[tour_copy[i]] < 2'd2) begin
            city_count[tour_copy[i]]++;
          end
        end
        for (int i = 0; i < span; i++) begin
          if (city_count[i] != 2'd1) all_once = 1'b0;
        end
        r.is_permutation = all_once && !r.entry_out_of_range;
      end
    endcase
    return r;
  endfunction

  task automatic compare_result();
    tour_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result read_value %0d is_permutation %0b out_of_range %0b",
               $time, read_value, is_permutation, entry_out_of_range);
    end else begin
      want = expected_results.pop_front();
      if (read_value !== want.read_value) begin
        mismatch_count++;
        $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                 read_value);
      end
      if (is_permutation !== want.is_permutation) begin
        mismatch_count++;
        $display("%0t: is_permutation expected %0b actual %0b", $time,
                 want.is_permutation, is_permutation);
      end
      if (entry_out_of_range !== want.entry_out_of_range) begin
        mismatch_count++;
        $display("%0t: entry_out_of_range expected %0b actual %0b", $time,
                 want.entry_out_of_range, entry_out_of_range);
      end
    end
  endtask

  // result side: check, then random stall bursts or a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) compare_result();
      if (hold_off_taken != hold_off_asked) begin
        hold_off_taken <= hold_off_taken + 1;
        stall_left <= LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < ready_gap_pct) begin
        stall_left <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(op_t kind, bit [9:0] pos_a, bit [9:0] pos_b,
                              logic signed [15:0] value);
    tour_result_t r;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    position_a  <= pos_a;
    position_b  <= pos_b;
    write_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_tour_request(kind, pos_a, pos_b, value);
    expected_results.push_back(r);
    requests_sent++;
    op_count[kind]++;
    if (kind == OP_CHECK && !r.is_permutation) broken_tours++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tour_length(int len);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_BITS'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    tour_length_copy = LEN_BITS'(len);
    length_settings++;
  endtask

  task automatic write_shuffled_tour(int n);
    int city [];
    int j;
    int t;
    city = new[n];
    foreach (city[i]) city[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = city[i];
      city[i] = city[j];
      city[j] = t;
    end
    foreach (city[i]) send_request(OP_WRITE, i, $urandom_range(0, 1023), city[i]);
  endtask

  // entries 0..LONG_TOUR-1 are always written once the long tour is in place;
  // reads, reversals and checks stay inside that prefix
  task automatic random_request(int span);
    int                 sel;
    int                 reach;
    bit [9:0]           a;
    bit [9:0]           b;
    logic signed [15:0] v;
    sel = $urandom_range(0, 99);
    reach = (span < LONG_TOUR) ? span : LONG_TOUR;
    a = $urandom_range(0, 1023);
    b = $urandom_range(0, 1023);
    v = $urandom;
    if (sel < 40) begin
      if (span > reach || (reach > 0 && $urandom_range(0, 4) != 0)) begin
        a = $urandom_range(0, reach - 1);
        b = $urandom_range(0, reach - 1);
      end
      send_request(OP_REVERSE, a, b, v);
    end else if (sel < 60) begin
      a = $urandom_range(0, LONG_TOUR - 1);
      send_request(OP_READ, a, b, v);
    end else if (sel < 75 && span == reach) begin
      send_request(OP_CHECK, a, b, v);
    end else if (sel < 90) begin
      if (span < GENOME_MAX) a = $urandom_range(span, GENOME_MAX - 1);
      send_request(OP_WRITE, a, b, v);
    end else begin
      // corrupt one tour entry: duplicate city, negative or too large
      if (reach > 0) begin
        a = $urandom_range(0, reach - 1);
        case ($urandom_range(0, 2))
          0: v = $urandom_range(0, span - 1);
          1: v = -$signed($urandom_range(1, 32768));
          default: v = $urandom_range(span, 32767);
        endcase
      end
      send_request(OP_WRITE, a, b, v);
    end
  endtask

  task automatic test_directed_ops();
    set_tour_length(4);
    send_request(OP_WRITE, 0, 10'h000, 2);
    send_request(OP_WRITE, 1, 10'h3FF, 0);
    send_request(OP_WRITE, 2, 10'h000, 3);
    send_request(OP_WRITE, 3, 10'h3FF, 1);
    send_request(OP_WRITE, 1023, 0, 16'sh7FFF);
    send_request(OP_READ, 1023, 1023, 0);
    send_request(OP_WRITE, 1023, 0, -16'sd32768);
    send_request(OP_READ, 1023, 0, 0);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_REVERSE, 0, 3, 0);
    send_request(OP_REVERSE, 3, 1, 0);
    send_request(OP_REVERSE, 2, 2, 0);
    send_request(OP_REVERSE, 0, 4, 0);
    send_request(OP_REVERSE, 1023, 0, 0);
    send_request(OP_READ, 0, 0, 0);
    send_request(OP_CHECK, 1023, 1023, -1);
    send_request(OP_WRITE, 3, 0, tour_copy[0]);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_WRITE, 3, 0, -1);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_WRITE, 3, 0, 4);
    send_request(OP_CHECK, 0, 0, 0);
  endtask

  task automatic test_length_extremes();
    set_tour_length(0);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_REVERSE, 0, 1, 0);
    send_request(OP_READ, 0, 0, 0);
    set_tour_length(1);
    send_request(OP_WRITE, 0, 0, 0);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_WRITE, 0, 0, 1);
    send_request(OP_CHECK, 0, 0, 0);
  endtask

  task automatic test_long_tour();
    send_gap_pct  = 20;
    ready_gap_pct = 20;
    set_tour_length(LONG_TOUR);
    write_shuffled_tour(LONG_TOUR);
    send_request(OP_CHECK, 0, 0, 0);
    send_request(OP_REVERSE, 0, 10'(LONG_TOUR - 1), 0);
    send_request(OP_READ, 0, 0, 0);
    send_request(OP_READ, 10'(LONG_TOUR - 1), 0, 0);
    send_request(OP_REVERSE, 10'($urandom_range(0, LONG_TOUR - 1)),
                 10'($urandom_range(0, LONG_TOUR - 1)), 0);
    send_request(OP_CHECK, 0, 0, 0);
    // length beyond the store: reversals inside the tour still apply
    set_tour_length(2047);
    send_request(OP_REVERSE, 10'(LONG_TOUR - 1), 0, 0);
    send_request(OP_READ, 0, 0, 0);
    set_tour_length(LONG_TOUR);
    send_request(OP_WRITE, 5, 0, 16'(LONG_TOUR));
    send_request(OP_CHECK, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    send_gap_pct  = 0;
    ready_gap_pct = 0;
    set_tour_length(16);
    hold_off_asked++;
    repeat (8) send_request(OP_READ, 10'($urandom_range(0, LONG_TOUR - 1)),
                            $urandom_range(0, 1023), 0);
    send_request(OP_REVERSE, 0, 15, 0);
    send_request(OP_CHECK, 0, 0, 0);
  endtask

  task automatic test_random_tours();
    int first;
    int pick;
    int len;
    int span;
    first = requests_sent;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      if (requests_sent - first >= RANDOM_REQUESTS - QUIET_TAIL) begin
        send_gap_pct  = 0;
        ready_gap_pct = 0;
      end else begin
        send_gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        ready_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) len = 0;
      else if (pick < 9) len = $urandom_range(GENOME_MAX + 1, 2047);
      else if (pick < 17) len = $urandom_range(25, LONG_TOUR);
      else len = $urandom_range(1, 24);
      set_tour_length(len);
      span = (len > GENOME_MAX) ? GENOME_MAX : len;
      if (span <= 24 && $urandom_range(0, 3) != 0) write_shuffled_tour(span);
      repeat ($urandom_range(8, 30)) random_request(span);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_length_extremes();
    test_long_tour();
    test_output_backpressure();
    test_random_tours();
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests: %0d writes, %0d reads, %0d reversals, %0d checks",
             requests_sent, op_count[OP_WRITE], op_count[OP_READ], op_count[OP_REVERSE],
             op_count[OP_CHECK]);
    $display("%0d checks found a broken tour, %0d length settings, %0d mismatches",
             broken_tours, length_settings, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tour_store_reverse_and_check_top regression: pass");
    end else begin
      $display("tour_store_reverse_and_check_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tsrc_pkg.sv
rtl/tsrc_ram.sv
rtl/tour_store_reverse_and_check_top.sv
tb/tb_tour_store_reverse_and_check_top.sv
